// ----- sv/tldn_pkg.sv -----
package tldn_pkg;

  // Field widths
  localparam int unsigned SecW   = 7;
  localparam int unsigned LightW = 12;
  localparam int unsigned TickW  = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  // Reset values of the configuration registers
  localparam logic [SecW-1:0]   GreenTimeRst   = SecW'(5);
  localparam logic [SecW-1:0]   YellowTimeRst  = SecW'(2);
  localparam logic [SecW-1:0]   RedTimeRst     = SecW'(5);
  localparam logic [LightW-1:0] ThresholdRst   = LightW'(1000);
  localparam logic [SecW-1:0]   PedLimitRst    = SecW'(2);
  localparam logic [TickW-1:0]  TicksPerSecRst = TickW'(1000);
  localparam logic [TickW-1:0]  BlinkHalfRst   = TickW'(500);
  localparam logic [TickW-1:0]  DebounceRst    = TickW'(200);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GREEN_TIME        = 3'd0,
    CFG_YELLOW_TIME       = 3'd1,
    CFG_RED_TIME          = 3'd2,
    CFG_LIGHT_THRESHOLD   = 3'd3,
    CFG_PEDESTRIAN_LIMIT  = 3'd4,
    CFG_TICKS_PER_SECOND  = 3'd5,
    CFG_BLINK_HALF_PERIOD = 3'd6,
    CFG_DEBOUNCE_TICKS    = 3'd7
  } cfg_idx_e;

  // Traffic phase
  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2
  } phase_e;

  // One tick: sensor sample and button level
  typedef struct packed {
    logic [LightW-1:0] light_level;
    logic              button_pressed;
  } in_t;

  // One result: lamps and display
  typedef struct packed {
    logic            red_lamp;
    logic            yellow_lamp;
    logic            green_lamp;
    logic            street_lamp;
    logic            show_dashes;
    logic [SecW-1:0] display_seconds;
  } out_t;

endpackage

// ----- sv/traffic_light_day_night_controller_core.sv -----
// Traffic light controller with day/night mode and pedestrian button.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per
// millisecond tick, carrying the light sample and the button level.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
// transfer per input tick, in order, with lamp states and display value.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (green, yellow, red time, light threshold, pedestrian limit, ticks per
// second, blink half period, debounce ticks); write only while idle.
//
// A tick's result is registered and valid in the next cycle. Throughput
// is one tick per cycle unless the receiver stalls; the whole tick update
// (counters, compares, phase step) is a short combinational pass ahead of
// the output register. in_stall_o rises only while a result sits in the
// output register and the receiver stalls; the result then holds.
// Reset restores all configuration defaults, puts the phase at green
// with 5 seconds, clears the tick, blink and lockout counters, and
// empties the output register.
module traffic_light_day_night_controller_core
  import tldn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o
);

  // Configuration registers
  logic [SecW-1:0]   green_time_q, yellow_time_q, red_time_q, ped_limit_q;
  logic [LightW-1:0] threshold_q;
  logic [TickW-1:0]  ticks_per_sec_q, blink_half_q, debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      green_time_q    <= GreenTimeRst;
      yellow_time_q   <= YellowTimeRst;
      red_time_q      <= RedTimeRst;
      threshold_q     <= ThresholdRst;
      ped_limit_q     <= PedLimitRst;
      ticks_per_sec_q <= TicksPerSecRst;
      blink_half_q    <= BlinkHalfRst;
      debounce_q      <= DebounceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GREEN_TIME:        green_time_q    <= cfg_wdata_i[SecW-1:0];
        CFG_YELLOW_TIME:       yellow_time_q   <= cfg_wdata_i[SecW-1:0];
        CFG_RED_TIME:          red_time_q      <= cfg_wdata_i[SecW-1:0];
        CFG_LIGHT_THRESHOLD:   threshold_q     <= cfg_wdata_i[LightW-1:0];
        CFG_PEDESTRIAN_LIMIT:  ped_limit_q     <= cfg_wdata_i[SecW-1:0];
        CFG_TICKS_PER_SECOND:  ticks_per_sec_q <= cfg_wdata_i[TickW-1:0];
        CFG_BLINK_HALF_PERIOD: blink_half_q    <= cfg_wdata_i[TickW-1:0];
        CFG_DEBOUNCE_TICKS:    debounce_q      <= cfg_wdata_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: output register parts the two sides
  logic out_valid_q, in_accept, out_free;
  out_t out_data_q, out_data_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign in_accept  = in_valid_i && out_free;

  // Tick state
  phase_e           phase_q, phase_d;
  logic [SecW-1:0]  secs_q, secs_d;
  logic [TickW-1:0] sec_cnt_q, sec_cnt_d;
  logic [TickW-1:0] blink_cnt_q, blink_cnt_d;
  logic             blink_on_q, blink_on_d;
  logic [TickW-1:0] lockout_q, lockout_d;

  logic             night;
  logic [TickW-1:0] sec_inc, blink_inc, lockout_dec;
  phase_e           step_phase;
  logic [SecW-1:0]  step_secs;
  logic             press;

  assign night       = in_data_i.light_level < threshold_q;
  assign sec_inc     = (sec_cnt_q == '1) ? sec_cnt_q : sec_cnt_q + TickW'(1);
  assign blink_inc   = (blink_cnt_q == '1) ? blink_cnt_q : blink_cnt_q + TickW'(1);
  assign lockout_dec = (lockout_q != '0) ? lockout_q - TickW'(1) : lockout_q;
  assign press       = in_data_i.button_pressed && (lockout_dec == '0);

  // Countdown step: decrement, or move to next phase at zero
  always_comb begin
    step_phase = phase_q;
    step_secs  = secs_q;
    if (secs_q != '0) begin
      step_secs = secs_q - SecW'(1);
    end else begin
      unique case (phase_q)
        PH_GREEN: begin
          step_phase = PH_YELLOW;
          step_secs  = yellow_time_q;
        end
        PH_YELLOW: begin
          step_phase = PH_RED;
          step_secs  = red_time_q;
        end
        default: begin
          step_phase = PH_GREEN;
          step_secs  = green_time_q;
        end
      endcase
    end
  end

  // Next tick state and result
  always_comb begin
    sec_cnt_d   = sec_inc;
    blink_cnt_d = blink_inc;
    blink_on_d  = blink_on_q;
    lockout_d   = lockout_dec;
    phase_d     = phase_q;
    secs_d      = secs_q;
    out_data_d  = '0;
    if (night) begin
      if (blink_inc >= blink_half_q) begin
        blink_cnt_d = '0;
        blink_on_d  = !blink_on_q;
      end
      phase_d                 = PH_GREEN;
      secs_d                  = green_time_q;
      out_data_d.yellow_lamp  = blink_on_d;
      out_data_d.street_lamp  = 1'b1;
      out_data_d.show_dashes  = 1'b1;
    end else begin
      if (sec_inc >= ticks_per_sec_q) begin
        sec_cnt_d = '0;
        phase_d   = step_phase;
        secs_d    = step_secs;
      end
      if (press) begin
        if (phase_d == PH_GREEN && secs_d > ped_limit_q) begin
          secs_d = ped_limit_q;
        end
        lockout_d = debounce_q;
      end
      out_data_d.red_lamp        = (phase_d == PH_RED);
      out_data_d.yellow_lamp     = (phase_d == PH_YELLOW);
      out_data_d.green_lamp      = (phase_d == PH_GREEN);
      out_data_d.display_seconds = secs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_GREEN;
      secs_q      <= GreenTimeRst;
      sec_cnt_q   <= '0;
      blink_cnt_q <= '0;
      blink_on_q  <= 1'b0;
      lockout_q   <= '0;
    end else if (in_accept) begin
      phase_q     <= phase_d;
      secs_q      <= secs_d;
      sec_cnt_q   <= sec_cnt_d;
      blink_cnt_q <= blink_cnt_d;
      blink_on_q  <= blink_on_d;
      lockout_q   <= lockout_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // Night result: only yellow may light, display blank
  a_night_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.street_lamp |->
      !out_data_o.red_lamp && !out_data_o.green_lamp &&
      out_data_o.show_dashes && out_data_o.display_seconds == '0)
    else $error("night result has day lamps or display");

  // Day result: exactly one traffic lamp
  a_day_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.street_lamp |->
      $onehot({out_data_o.red_lamp, out_data_o.yellow_lamp, out_data_o.green_lamp}))
    else $error("day result lamps not one-hot");

  // Input only stalls while a result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output register");

  // Night tick reloads green
  a_night_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && night |=> phase_q == PH_GREEN && secs_q == $past(green_time_q))
    else $error("night tick did not reload green");

  // Accepted press loads the lockout
  a_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !night && press |=> lockout_q == $past(debounce_q))
    else $error("press did not load lockout");
`endif

endmodule

// ----- tb/sv/tldn_lamp_checker.sv -----
module tldn_lamp_checker
  import tldn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_t               out_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 night_o
);

  // Shadow copy of the register file
  logic [SecW-1:0]   green_t, yellow_t, red_t, ped_lim;
  logic [LightW-1:0] thresh;
  logic [TickW-1:0]  tps, blink_half, debounce;

  // Shadow controller state
  phase_e            ph;
  logic [SecW-1:0]   secs;
  logic [TickW-1:0]  sec_cnt, blink_cnt, lockout;
  logic              blink_on;

  // Lamp states owed by the block, oldest first
  out_t lamps_due[$];

  // Advance the shadow controller by one tick and return its lamp state
  function automatic out_t next_lamps(input in_t t);
    out_t r;
    r = '0;
    if (sec_cnt != '1) sec_cnt = sec_cnt + TickW'(1);
    if (blink_cnt != '1) blink_cnt = blink_cnt + TickW'(1);
    if (lockout != '0) lockout = lockout - TickW'(1);

    if (t.light_level < thresh) begin
      // night: blink yellow, hold green with full time, button ignored
      if (blink_cnt >= blink_half) begin
        blink_cnt = '0;
        blink_on  = ~blink_on;
      end
      ph   = PH_GREEN;
      secs = green_t;
      r.yellow_lamp = blink_on;
      r.street_lamp = 1'b1;
      r.show_dashes = 1'b1;
      return r;
    end

    // day: one countdown step per second
    if (sec_cnt >= tps) begin
      sec_cnt = '0;
      if (secs != '0) begin
        secs = secs - SecW'(1);
      end else begin
        case (ph)
          PH_GREEN: begin
            ph   = PH_YELLOW;
            secs = yellow_t;
          end
          PH_YELLOW: begin
            ph   = PH_RED;
            secs = red_t;
          end
          default: begin
            ph   = PH_GREEN;
            secs = green_t;
          end
        endcase
      end
    end

    // pedestrian press outside lockout
    if (t.button_pressed && lockout == '0) begin
      if (ph == PH_GREEN && secs > ped_lim) secs = ped_lim;
      lockout = debounce;
    end

    r.red_lamp        = (ph == PH_RED);
    r.yellow_lamp     = (ph == PH_YELLOW);
    r.green_lamp      = (ph == PH_GREEN);
    r.display_seconds = secs;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [SecW-1:0] want,
                                      input logic [SecW-1:0] got);
    if (want !== got) begin
      if (errors_o < 10)
        $display("mismatch on %s at result %0d: expected %0d, got %0d",
                 what, checked_o, want, got);
      errors_o++;
    end
  endfunction

  // Track config writes, predict on each input transfer, check each output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    out_t got;
    if (!rst_ni) begin
      green_t    = GreenTimeRst;
      yellow_t   = YellowTimeRst;
      red_t      = RedTimeRst;
      thresh     = ThresholdRst;
      ped_lim    = PedLimitRst;
      tps        = TicksPerSecRst;
      blink_half = BlinkHalfRst;
      debounce   = DebounceRst;
      ph         = PH_GREEN;
      secs       = GreenTimeRst;
      sec_cnt    = '0;
      blink_cnt  = '0;
      lockout    = '0;
      blink_on   = 1'b0;
      lamps_due.delete();
      errors_o   = 0;
      pending_o  = 0;
      checked_o  = 0;
      night_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GREEN_TIME:        green_t    = cfg_wdata_i[SecW-1:0];
          CFG_YELLOW_TIME:       yellow_t   = cfg_wdata_i[SecW-1:0];
          CFG_RED_TIME:          red_t      = cfg_wdata_i[SecW-1:0];
          CFG_LIGHT_THRESHOLD:   thresh     = cfg_wdata_i[LightW-1:0];
          CFG_PEDESTRIAN_LIMIT:  ped_lim    = cfg_wdata_i[SecW-1:0];
          CFG_TICKS_PER_SECOND:  tps        = cfg_wdata_i[TickW-1:0];
          CFG_BLINK_HALF_PERIOD: blink_half = cfg_wdata_i[TickW-1:0];
          default:               debounce   = cfg_wdata_i[TickW-1:0];
        endcase
      end

      if (in_valid_i && !in_stall_i) lamps_due.push_back(next_lamps(in_data_i));

      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (lamps_due.size() == 0) begin
          if (errors_o < 10) $display("unexpected result transfer: %p", got);
          errors_o++;
        end else begin
          want = lamps_due.pop_front();
          check_field("red_lamp", SecW'(want.red_lamp), SecW'(got.red_lamp));
          check_field("yellow_lamp", SecW'(want.yellow_lamp), SecW'(got.yellow_lamp));
          check_field("green_lamp", SecW'(want.green_lamp), SecW'(got.green_lamp));
          check_field("street_lamp", SecW'(want.street_lamp), SecW'(got.street_lamp));
          check_field("show_dashes", SecW'(want.show_dashes), SecW'(got.show_dashes));
          check_field("display_seconds", want.display_seconds, got.display_seconds);
          if (want.street_lamp) night_o++;
          checked_o++;
        end
      end
      pending_o = lamps_due.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import tldn_pkg::*;

  localparam int Limit = 400000;

  logic               clk_i     = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  in_t                in_data   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  out_t               out_data;

  int errors, pending, checked, night;
  int cycles   = 0;
  int sent     = 0;
  int settings = 0;
  bit calm     = 1'b0;
  bit dark     = 1'b0;
  logic [CfgW-1:0] regs [8];

  traffic_light_day_night_controller_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  tldn_lamp_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .night_o     (night)
  );

  always #4 clk_i = ~clk_i;

  // Run watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver back-pressure, quiet inside the calm window
  always @(posedge clk_i) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(0, 99) < 12);
  end

  // One tick transfer; stall is sampled mid-cycle where it is stable
  task automatic send_tick(input in_t d);
    logic stalled;
    calm = (sent >= 350 && sent < 500);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
    sent++;
  endtask

  // Stop sending and wait for every owed result
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Write the whole register file while the block is idle
  task automatic reconfigure(input int g, input int y, input int r, input int thr,
                             input int ped, input int tps, input int blink, input int deb);
    settle();
    regs[CFG_GREEN_TIME]        = CfgW'(g);
    regs[CFG_YELLOW_TIME]       = CfgW'(y);
    regs[CFG_RED_TIME]          = CfgW'(r);
    regs[CFG_LIGHT_THRESHOLD]   = CfgW'(thr);
    regs[CFG_PEDESTRIAN_LIMIT]  = CfgW'(ped);
    regs[CFG_TICKS_PER_SECOND]  = CfgW'(tps);
    regs[CFG_BLINK_HALF_PERIOD] = CfgW'(blink);
    regs[CFG_DEBOUNCE_TICKS]    = CfgW'(deb);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= cfg_idx_e'(i);
      cfg_wdata <= regs[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Light sample: mostly the current day or night band, some edges and noise
  function automatic logic [LightW-1:0] pick_light();
    logic [LightW-1:0] thr;
    thr = regs[CFG_LIGHT_THRESHOLD][LightW-1:0];
    case ($urandom_range(0, 19))
      0: return LightW'($urandom_range(0, 4095));
      1: return thr;
      2: return thr - LightW'(1);
      3: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: begin
        if (dark && thr != '0) return LightW'($urandom_range(0, thr - 1));
        return LightW'($urandom_range(thr, 4095));
      end
    endcase
  endfunction

  function automatic int pick_time();
    return ($urandom_range(0, 7) == 0) ? 127 : $urandom_range(0, 5);
  endfunction

  task automatic run_ticks(input int n);
    in_t d;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) dark = !dark;
      d.light_level    = pick_light();
      d.button_pressed = ($urandom_range(0, 99) < 25);
      send_tick(d);
    end
  endtask

  initial begin
    in_t d;
    int  edge_light [12];
    bit  edge_btn   [12];
    edge_light = '{4095, 0, 999, 1000, 1000, 4095, 'hAAA, 'h555, 0, 1, 2048, 4094};
    edge_btn   = '{0, 0, 1, 0, 1, 1, 1, 0, 1, 0, 1, 0};
    regs[CFG_GREEN_TIME]        = CfgW'(GreenTimeRst);
    regs[CFG_YELLOW_TIME]       = CfgW'(YellowTimeRst);
    regs[CFG_RED_TIME]          = CfgW'(RedTimeRst);
    regs[CFG_LIGHT_THRESHOLD]   = CfgW'(ThresholdRst);
    regs[CFG_PEDESTRIAN_LIMIT]  = CfgW'(PedLimitRst);
    regs[CFG_TICKS_PER_SECOND]  = TicksPerSecRst;
    regs[CFG_BLINK_HALF_PERIOD] = BlinkHalfRst;
    regs[CFG_DEBOUNCE_TICKS]    = DebounceRst;

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: threshold edges, night button, press cut and lockout
    for (int i = 0; i < 12; i++) begin
      d.light_level    = LightW'(edge_light[i]);
      d.button_pressed = edge_btn[i];
      send_tick(d);
    end

    // Short periods so all phases, blinks and lockouts turn over
    reconfigure(3, 1, 2, 2048, 1, 4, 3, 5);
    run_ticks(200);
    // Zero times and periods: a step every tick
    reconfigure(0, 0, 0, 2048, 0, 0, 0, 0);
    run_ticks(100);
    // Threshold zero: never night
    reconfigure(2, 1, 1, 0, 1, 2, 2, 3);
    run_ticks(40);
    // Top values everywhere
    reconfigure(127, 127, 127, 4095, 127, 65535, 65535, 65535);
    run_ticks(60);
    // Long phases with a fast second
    reconfigure(127, 127, 127, 1000, 99, 1, 1, 65535);
    run_ticks(60);
    repeat (4) begin
      reconfigure(pick_time(), pick_time(), pick_time(), $urandom_range(0, 4095),
                  $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 5),
                  $urandom_range(0, 30));
      run_ticks(110);
    end

    settle();
    repeat (4) @(posedge clk_i);

    $display("%0d ticks checked (%0d at night) over %0d register settings",
             checked, night, settings + 1);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
